### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication
`define CHK_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### design/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Types, constants and round functions shared by the SHA-256 core.
// ----------------------------------------------------------------------------
`default_nettype none

package s256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned BlockW     = BlockBytes * 8;
	localparam int unsigned NumWords   = 8;
	localparam int unsigned LenPos     = 56;
	localparam logic [7:0]  PadByte    = 8'h80;
	localparam logic [5:0]  LastPos    = 6'd63;
	localparam logic [5:0]  LastRound  = 6'd63;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_ADD,
		ST_PAD,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic load;
		logic round;
		logic add;
		logic reinit;
	} rnd_ctl_t;

	typedef struct packed {
		logic       push;
		logic [7:0] data;
		logic       sched;
	} sch_ctl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t ssig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t init_h(input logic [2:0] idx);
		word_t r;
		case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			3'd7: r = 32'h5be0cd19;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] idx);
		word_t r;
		case (idx)
			6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### design/s256_sched.sv
// ----------------------------------------------------------------------------
// s256_sched
// Block buffer and message schedule window: bytes shift in from the low end,
// then each round shifts out w[i] and shifts in w[i+16].
// ----------------------------------------------------------------------------
`default_nettype none

module s256_sched (
	input  logic                clk,
	input  s256_pkg::sch_ctl_t  ctl,
	output s256_pkg::word_t     w_cur
);
	import s256_pkg::*;

	logic [BlockW-1:0] win_q;
	word_t             w_new;

	// word j of the window sits at bits [BlockW-1-32*j -: 32]
	assign w_cur = win_q[BlockW-1 -: 32];
	assign w_new = ssig1(win_q[BlockW-1-32*14 -: 32]) + win_q[BlockW-1-32*9 -: 32]
		+ ssig0(win_q[BlockW-1-32 -: 32]) + w_cur;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_q <= {win_q[BlockW-9:0], ctl.data};
		end else if (ctl.sched) begin
			win_q <= {win_q[BlockW-33:0], w_new};
		end
	end

endmodule

`default_nettype wire

### design/s256_round.sv
// ----------------------------------------------------------------------------
// s256_round
// Hash state and the shared compression round, one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_round (
	input  logic                clk,
	input  logic                arst_n,
	input  s256_pkg::rnd_ctl_t  ctl,
	input  logic [5:0]          k_idx,
	input  s256_pkg::word_t     w,
	output s256_pkg::word_t     hash [8]
);
	import s256_pkg::*;

	word_t hash_q [NumWords];
	word_t v_q    [NumWords];
	word_t t1;
	word_t t2;

	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(k_idx) + w;
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumWords; i++) hash_q[i] <= init_h(3'(i));
		end else if (ctl.reinit) begin
			for (int i = 0; i < NumWords; i++) hash_q[i] <= init_h(3'(i));
		end else if (ctl.add) begin
			for (int i = 0; i < NumWords; i++) hash_q[i] <= hash_q[i] + v_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= hash_q;
		end else if (ctl.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	assign hash = hash_q;

endmodule

`default_nettype wire

### design/sha256_byte_stream_hasher_core.sv
// A byte transaction is taken only while the sequencer is idle; each 64th byte
// starts 64 rounds of the shared round unit, then one hash update. End of
// message shifts pad and length bytes one per cycle to the end of the block
// (over one or two blocks); each padded block is compressed the same way, then
// the digest register is loaded. A new message may start while the digest waits.
// Reset clears the sequencer, counters and output valid and loads the initial hash.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 over a byte stream: sequencer, padding and digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        has_byte,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        digest_valid,
	input  logic        digest_ready,
	output logic [31:0] digest_word0,
	output logic [31:0] digest_word1,
	output logic [31:0] digest_word2,
	output logic [31:0] digest_word3,
	output logic [31:0] digest_word4,
	output logic [31:0] digest_word5,
	output logic [31:0] digest_word6,
	output logic [31:0] digest_word7
);
	import s256_pkg::*;

	st_t         state_q;
	st_t         state_nxt;
	logic [5:0]  fill_q;
	logic [60:0] count_q;
	logic [5:0]  rnd_q;
	logic        pad_q;
	logic        first_q;
	logic        len_ok_q;
	logic        final_q;
	logic        out_valid_q;
	word_t       dig_q [NumWords];

	sch_ctl_t    sch_ctl;
	rnd_ctl_t    rnd_ctl;
	word_t       w_cur;
	word_t       hash [8];

	logic        accept;
	logic        msg_push;
	logic        done_go;
	logic [63:0] bit_len;
	logic [7:0]  pad_data;

	assign accept   = item_valid && item_ready;
	assign msg_push = accept && has_byte;
	assign done_go  = (state_q == ST_DONE) && (!out_valid_q || digest_ready);
	assign bit_len  = {count_q, 3'b000};

	always_comb begin
		if (first_q) begin
			pad_data = PadByte;
		end else if (len_ok_q && fill_q >= 6'(LenPos)) begin
			pad_data = bit_len[{3'd7 - fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_data = 8'h00;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (msg_push && fill_q == LastPos) begin
					state_nxt = ST_COMP;
				end else if (accept && end_of_message) begin
					state_nxt = ST_PAD;
				end
			end
			ST_COMP: begin
				if (rnd_q == LastRound) state_nxt = ST_ADD;
			end
			ST_ADD: begin
				if (final_q) begin
					state_nxt = ST_DONE;
				end else if (pad_q) begin
					state_nxt = ST_PAD;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (fill_q == LastPos) state_nxt = ST_COMP;
			end
			ST_DONE: begin
				if (done_go) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item_ready     = (state_q == ST_IDLE);
		sch_ctl.push   = msg_push || (state_q == ST_PAD);
		sch_ctl.data   = (state_q == ST_PAD) ? pad_data : data_byte;
		sch_ctl.sched  = (state_q == ST_COMP);
		rnd_ctl.load   = sch_ctl.push && fill_q == LastPos;
		rnd_ctl.round  = (state_q == ST_COMP);
		rnd_ctl.add    = (state_q == ST_ADD);
		rnd_ctl.reinit = done_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			rnd_q       <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			final_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (sch_ctl.push) fill_q <= fill_q + 6'd1;
			rnd_q <= (state_q == ST_COMP) ? rnd_q + 6'd1 : 6'd0;

			if (done_go) begin
				count_q <= '0;
			end else if (msg_push) begin
				count_q <= count_q + 61'd1;
			end

			if (done_go) begin
				pad_q    <= 1'b0;
				first_q  <= 1'b0;
				len_ok_q <= 1'b0;
				final_q  <= 1'b0;
			end else if (accept && end_of_message) begin
				pad_q   <= 1'b1;
				first_q <= 1'b1;
			end else if (state_q == ST_PAD) begin
				first_q <= 1'b0;
				// length goes in this block if the pad byte fit before it,
				// otherwise in the block after the wrap
				if ((first_q && fill_q < 6'(LenPos)) || fill_q == LastPos) begin
					len_ok_q <= 1'b1;
				end
				if (len_ok_q && fill_q == LastPos) final_q <= 1'b1;
			end

			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_go) dig_q <= hash;
	end

	s256_sched u_sched (
		.clk   (clk),
		.ctl   (sch_ctl),
		.w_cur (w_cur)
	);

	s256_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rnd_ctl),
		.k_idx  (rnd_q),
		.w      (w_cur),
		.hash   (hash)
	);

	assign digest_valid = out_valid_q;
	assign digest_word0 = dig_q[0];
	assign digest_word1 = dig_q[1];
	assign digest_word2 = dig_q[2];
	assign digest_word3 = dig_q[3];
	assign digest_word4 = dig_q[4];
	assign digest_word5 = dig_q[5];
	assign digest_word6 = dig_q[6];
	assign digest_word7 = dig_q[7];

endmodule

`default_nettype wire

### design/s256_chk.sv
// ----------------------------------------------------------------------------
// s256_chk
// Port-level checks on the SHA-256 core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module s256_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        end_of_message,
	input logic        digest_valid,
	input logic        digest_ready,
	input logic [31:0] digest_word0,
	input logic [31:0] digest_word1,
	input logic [31:0] digest_word2,
	input logic [31:0] digest_word3,
	input logic [31:0] digest_word4,
	input logic [31:0] digest_word5,
	input logic [31:0] digest_word6,
	input logic [31:0] digest_word7
);

	logic         item_acc;
	logic         stall;
	logic [255:0] dig_all;

	assign item_acc = item_valid && item_ready;
	assign stall    = digest_valid && !digest_ready;
	assign dig_all  = {digest_word0, digest_word1, digest_word2, digest_word3,
		digest_word4, digest_word5, digest_word6, digest_word7};

	// a stalled digest transaction holds
	`CHK_NEXT(a_dig_hold, stall, digest_valid, "digest valid dropped while stalled")
	`CHK_NEXT(a_dig_stable, stall, $stable(dig_all), "digest changed while stalled")

	// a digest only follows an end mark, never a plain byte
	`CHK_NEXT(a_no_spurious, item_acc && !end_of_message && !digest_valid, !digest_valid, "digest without end of message")

	// finishing a message always takes padding cycles
	`CHK_NEXT(a_busy_after_end, item_acc && end_of_message, !item_ready, "ready right after end of message")

endmodule

bind sha256_byte_stream_hasher_core s256_chk u_s256_chk (.*);

`default_nettype wire

### test/sha256_byte_stream_hasher_core_test.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher core test
// Feeds byte streams cut into messages of many lengths, computes the
// expected digest of each message in the bench and checks every digest word.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL   = 1450;
	localparam int MSG_GOAL    = 24;
	localparam int HOLD_CYCLES = 1000;
	localparam int TAIL_CYCLES = 400;

	localparam bit [0:63][31:0] RK = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [0:7][31:0] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// lengths around the pad and block boundaries
	localparam bit [0:11][7:0] EDGE_LEN = {
		8'd55, 8'd56, 8'd57, 8'd63, 8'd64, 8'd65,
		8'd119, 8'd120, 8'd121, 8'd127, 8'd128, 8'd129
	};

	typedef struct {
		bit       has_byte;
		bit [7:0] data_byte;
		bit       eom;
		bit       pause;   // sender waits here until all digests are back
	} byte_item_t;

	typedef bit [255:0] digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        has_byte = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_message = 1'b0;
	logic        digest_valid;
	logic        digest_ready = 1'b0;
	logic [31:0] digest_word0, digest_word1, digest_word2, digest_word3;
	logic [31:0] digest_word4, digest_word5, digest_word6, digest_word7;

	byte_item_t feed_q[$];
	digest_t    digest_q[$];
	byte_item_t next_item;

	// bench copy of the hasher state
	bit [31:0] hash_h[8];
	bit [7:0]  blk[64];
	bit [5:0]  fill_pos;
	bit [60:0] msg_bytes;

	int        bad_n = 0;
	int        digests_seen = 0;
	int        cycle_n = 0;
	int        useful_n = 0;
	int        msg_n = 0;
	int        len;
	int        w;
	logic      rx_hold = 1'b0;
	logic      quiet;
	logic [255:0] got;
	digest_t   want;

	sha256_byte_stream_hasher_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.has_byte       (has_byte),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.digest_valid   (digest_valid),
		.digest_ready   (digest_ready),
		.digest_word0   (digest_word0),
		.digest_word1   (digest_word1),
		.digest_word2   (digest_word2),
		.digest_word3   (digest_word3),
		.digest_word4   (digest_word4),
		.digest_word5   (digest_word5),
		.digest_word6   (digest_word6),
		.digest_word7   (digest_word7)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_n <= cycle_n + 1;
	end

	// neither side idles at random inside this window
	assign quiet = (cycle_n >= 1500) && (cycle_n < 3500);

	function automatic bit [31:0] rot_r(input bit [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_init();
		int i;
		for (i = 0; i < 8; i++)
			hash_h[i] = IV[i];
		fill_pos = '0;
		msg_bytes = '0;
	endfunction

	function automatic void sha_compress();
		bit [31:0] sched[64];
		bit [31:0] v[8];
		bit [31:0] t1, t2, s0, s1;
		int i;
		for (i = 0; i < 16; i++)
			sched[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (i = 16; i < 64; i++) begin
			s0 = rot_r(sched[i-15], 7) ^ rot_r(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = rot_r(sched[i-2], 17) ^ rot_r(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
		end
		for (i = 0; i < 8; i++)
			v[i] = hash_h[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (rot_r(v[4], 6) ^ rot_r(v[4], 11) ^ rot_r(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + sched[i];
			t2 = (rot_r(v[0], 2) ^ rot_r(v[0], 13) ^ rot_r(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			hash_h[i] = hash_h[i] + v[i];
	endfunction

	// pad, length, final compression(s); queue the digest and start over
	function automatic void sha_finish();
		bit [63:0] nbits;
		digest_t   d;
		int p;
		int i;
		nbits = {msg_bytes, 3'b000};
		p = int'(fill_pos);
		blk[p] = 8'h80;
		p++;
		if (p > 56) begin
			while (p < 64) begin
				blk[p] = 8'h00;
				p++;
			end
			sha_compress();
			p = 0;
		end
		while (p < 56) begin
			blk[p] = 8'h00;
			p++;
		end
		for (i = 0; i < 8; i++)
			blk[56+i] = nbits[63-8*i -: 8];
		sha_compress();
		for (i = 0; i < 8; i++)
			d[255-32*i -: 32] = hash_h[i];
		digest_q.push_back(d);
		hash_init();
	endfunction

	function automatic void absorb_item(input bit hb, input bit [7:0] db, input bit eom);
		if (hb) begin
			blk[fill_pos] = db;
			fill_pos = fill_pos + 1'b1;
			msg_bytes = msg_bytes + 1'b1;
			if (fill_pos == 0)
				sha_compress();
		end
		if (eom)
			sha_finish();
	endfunction

	task automatic put(input bit hb, input bit [7:0] db, input bit eom, input bit pause);
		byte_item_t it;
		it.has_byte = hb;
		it.data_byte = db;
		it.eom = eom;
		it.pause = pause;
		feed_q.push_back(it);
		if (hb || eom)
			useful_n++;
	endtask

	// message of random bytes, closed either on its last byte or by a lone end mark
	task automatic queue_message(input int n);
		bit joined;
		int k;
		joined = (n > 0) && ($urandom_range(1) == 1);
		for (k = 0; k < n; k++) begin
			if ($urandom_range(15) == 0)
				put(1'b0, 8'($urandom_range(255)), 1'b0, 1'b0);
			put(1'b1, 8'($urandom_range(255)), joined && (k == n - 1), 1'b0);
		end
		if (!joined)
			put(1'b0, 8'($urandom_range(255)), 1'b1, 1'b0);
		msg_n++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			has_byte <= 1'b0;
			data_byte <= 8'h00;
			end_of_message <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				absorb_item(has_byte, data_byte, end_of_message);
			if (!item_valid || item_ready) begin
				if (feed_q.size() == 0 || feed_q[0].pause ||
						(!quiet && $urandom_range(99) < 30)) begin
					if (feed_q.size() != 0 && feed_q[0].pause && digest_q.size() == 0)
						void'(feed_q.pop_front());
					item_valid <= 1'b0;
				end else begin
					next_item = feed_q.pop_front();
					item_valid <= 1'b1;
					has_byte <= next_item.has_byte;
					data_byte <= next_item.data_byte;
					end_of_message <= next_item.eom;
				end
			end
		end
	end

	// receiver and digest check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_ready <= 1'b0;
		end else begin
			if (digest_valid && digest_ready) begin
				got = {digest_word0, digest_word1, digest_word2, digest_word3,
					digest_word4, digest_word5, digest_word6, digest_word7};
				if (digest_q.size() == 0) begin
					bad_n++;
					if (bad_n <= 10)
						$display("unexpected digest transaction: %h", got);
				end else begin
					want = digest_q.pop_front();
					for (w = 0; w < 8; w++) begin
						if (got[255-32*w -: 32] !== want[255-32*w -: 32]) begin
							bad_n++;
							if (bad_n <= 10)
								$display("digest_word%0d: expected %08h, got %08h",
									w, want[255-32*w -: 32], got[255-32*w -: 32]);
						end
					end
				end
				digests_seen <= digests_seen + 1;
			end
			digest_ready <= !rx_hold && (quiet || $urandom_range(99) >= 30);
		end
	end

	// long receiver hold-off: the core must back up and stall its input
	initial begin
		while (digests_seen < 6)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		hash_init();

		// directed: empty message with an ignored byte, noise, "abc" closed on
		// its last byte, extreme bytes closed by a lone end mark, back-to-back ends
		put(1'b0, 8'hff, 1'b1, 1'b0);
		put(1'b0, 8'ha5, 1'b0, 1'b0);
		put(1'b1, 8'h61, 1'b0, 1'b0);
		put(1'b1, 8'h62, 1'b0, 1'b0);
		put(1'b1, 8'h63, 1'b1, 1'b0);
		put(1'b1, 8'h00, 1'b0, 1'b0);
		put(1'b0, 8'h3c, 1'b0, 1'b0);
		put(1'b1, 8'hff, 1'b0, 1'b0);
		put(1'b0, 8'h5a, 1'b1, 1'b0);
		put(1'b1, 8'h80, 1'b1, 1'b0);
		put(1'b0, 8'h00, 1'b1, 1'b0);
		put(1'b0, 8'hff, 1'b1, 1'b0);
		put(1'b1, 8'h7f, 1'b0, 1'b0);
		put(1'b1, 8'h01, 1'b1, 1'b0);

		while (useful_n < ITEM_GOAL || msg_n < MSG_GOAL) begin
			case ($urandom_range(9))
				0, 1, 2: len = $urandom_range(8);
				3, 4, 5: len = int'(EDGE_LEN[$urandom_range(11)]);
				default: len = $urandom_range(100, 1);
			endcase
			queue_message(len);
			if (msg_n == 20 || (msg_n > 20 && $urandom_range(9) == 0))
				put(1'b0, 8'h00, 1'b0, 1'b1);
		end

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (feed_q.size() != 0 || item_valid)
			@(posedge clk);
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (bad_n == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
